/* src/b2d_pkg.sv */
// shared constants and power-of-ten table for the binary to decimal digit splitter
`timescale 1ns / 1ps

package b2d_pkg;

  localparam int unsigned DIGIT_WIDTH = 4;
  localparam int unsigned MAG_WIDTH   = 64;
  localparam int unsigned POS_WIDTH   = 5;

  // weight of the decimal position pos
  function automatic logic [MAG_WIDTH-1:0] pow10(input logic [POS_WIDTH-1:0] pos);
    logic [MAG_WIDTH-1:0] mag;
    unique case (pos)
      5'd0:    mag = 64'd1;
      5'd1:    mag = 64'd10;
      5'd2:    mag = 64'd100;
      5'd3:    mag = 64'd1000;
      5'd4:    mag = 64'd10000;
      5'd5:    mag = 64'd100000;
      5'd6:    mag = 64'd1000000;
      5'd7:    mag = 64'd10000000;
      5'd8:    mag = 64'd100000000;
      5'd9:    mag = 64'd1000000000;
      5'd10:   mag = 64'd10000000000;
      5'd11:   mag = 64'd100000000000;
      5'd12:   mag = 64'd1000000000000;
      5'd13:   mag = 64'd10000000000000;
      5'd14:   mag = 64'd100000000000000;
      5'd15:   mag = 64'd1000000000000000;
      5'd16:   mag = 64'd10000000000000000;
      5'd17:   mag = 64'd100000000000000000;
      5'd18:   mag = 64'd1000000000000000000;
      5'd19:   mag = 64'd10000000000000000000;
      default: mag = 64'd1;
    endcase
    return mag;
  endfunction

endpackage

/* src/b2d_dabble.sv */
// one shift-and-add-3 step of the binary to bcd conversion
`timescale 1ns / 1ps

module b2d_dabble #(
  parameter int unsigned NUM_DIGITS = 20
) (
  input  logic [NUM_DIGITS*b2d_pkg::DIGIT_WIDTH-1:0] bcd_i,
  input  logic                                       bit_i,
  output logic [NUM_DIGITS*b2d_pkg::DIGIT_WIDTH-1:0] bcd_o
);

  localparam int unsigned DW    = b2d_pkg::DIGIT_WIDTH;
  localparam int unsigned BCD_W = NUM_DIGITS * DW;

  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int unsigned i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_i[i*DW +: DW] >= DW'(5)) begin
        adj[i*DW +: DW] = bcd_i[i*DW +: DW] + DW'(3);
      end else begin
        adj[i*DW +: DW] = bcd_i[i*DW +: DW];
      end
    end
  end

  assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule

/* src/binary_to_decimal_digits_top.sv */
// binary to decimal digit splitter: double dabble conversion, then digit emission
`timescale 1ns / 1ps

// usage
// - raise start_i with value_i; the beat is taken when start_i is high and busy_o low
// - only the low VALUE_WIDTH bits of value_i are used
// - busy_o stays high from the cycle after the beat until the last digit is issued
// - one result per decimal digit, most significant first, leading zeros dropped;
//   a zero value gives a single digit 0 at magnitude 1
// - each result is on digit_o, magnitude_o, last_o for one cycle with valid_o high;
//   last_o marks the units digit; the receiver cannot stall
// timing
// - conversion takes VALUE_WIDTH steps of the shared shift-and-add-3 unit
// - then the digit positions are walked from the top at one position a cycle:
//   leading zeros are skipped, each remaining position emits one result
// - an item holds the block through conversion and emission (NUM_DIGITS = 20
//   at 64 bits); a new start can be taken in the cycle of the last result
// reset
// - rst_ni clears the sequencer and valid_o; no results are pending after reset
module binary_to_decimal_digits_top #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [63:0]                         value_i,
  output logic                                valid_o,
  output logic [b2d_pkg::DIGIT_WIDTH-1:0]     digit_o,
  output logic [b2d_pkg::MAG_WIDTH-1:0]       magnitude_o,
  output logic                                last_o
);

  localparam int unsigned DW         = b2d_pkg::DIGIT_WIDTH;
  localparam int unsigned NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned BCD_W      = NUM_DIGITS * DW;
  localparam int unsigned IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned CNT_W      = $clog2(VALUE_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   lead_q, lead_d;
  logic                   valid_q, valid_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_step;
  logic [DW-1:0]          digit_q, digit_d;
  logic [b2d_pkg::MAG_WIDTH-1:0] mag_q, mag_d;
  logic                   last_q, last_d;
  logic [DW-1:0]          top_digit;

  b2d_dabble #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_dabble (
    .bcd_i(bcd_q),
    .bit_i(val_q[VALUE_WIDTH-1]),
    .bcd_o(bcd_step)
  );

  assign top_digit = bcd_q[BCD_W-1 -: DW];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    lead_d  = lead_q;
    valid_d = 1'b0;
    val_d   = val_q;
    bcd_d   = bcd_q;
    digit_d = digit_q;
    mag_d   = mag_q;
    last_d  = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d   = value_i[VALUE_WIDTH-1:0];
          bcd_d   = '0;
          cnt_d   = CNT_W'(VALUE_WIDTH - 1);
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d = bcd_step;
        val_d = {val_q[VALUE_WIDTH-2:0], 1'b0};
        if (cnt_q == '0) begin
          idx_d   = IDX_W'(NUM_DIGITS - 1);
          lead_d  = 1'b1;
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_EMIT: begin
        if (lead_q && top_digit == '0 && idx_q != '0) begin
          // leading zero, skip
          bcd_d = {bcd_q[BCD_W-DW-1:0], {DW{1'b0}}};
          idx_d = idx_q - 1'b1;
        end else begin
          valid_d = 1'b1;
          digit_d = top_digit;
          mag_d   = b2d_pkg::pow10(b2d_pkg::POS_WIDTH'(idx_q));
          last_d  = (idx_q == '0);
          lead_d  = 1'b0;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            bcd_d = {bcd_q[BCD_W-DW-1:0], {DW{1'b0}}};
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      lead_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      lead_q  <= lead_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    bcd_q   <= bcd_d;
    digit_q <= digit_d;
    mag_q   <= mag_d;
    last_q  <= last_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign digit_o     = digit_q;
  assign magnitude_o = mag_q;
  assign last_o      = last_q;

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> digit_o <= DW'(9))
    else $error("digit out of decimal range");

  a_last_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> magnitude_o == b2d_pkg::MAG_WIDTH'(1))
    else $error("last beat not at units position");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_digits_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("gap between digit beats");

  a_no_beat_idle_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |=> !valid_o)
    else $error("result during conversion");

endmodule

/* dv/b2d_digit_monitor.sv */
// digit stream monitor: predicts each value's decimal digits and compares every result beat
`timescale 1ns / 1ps

module b2d_digit_monitor #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_o,
  input  logic [63:0]                     value_i,
  input  logic                            valid_o,
  input  logic [b2d_pkg::DIGIT_WIDTH-1:0] digit_o,
  input  logic [b2d_pkg::MAG_WIDTH-1:0]   magnitude_o,
  input  logic                            last_o,
  output int                              fail_count_o,
  output int                              outstanding_o
);

  localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_WIDTH);
  localparam logic [63:0] DECIMAL_BASE = 64'd10;
  localparam int unsigned MAX_DIGITS   = 20;

  typedef struct packed {
    logic [b2d_pkg::DIGIT_WIDTH-1:0] digit;
    logic [b2d_pkg::MAG_WIDTH-1:0]   magnitude;
    logic                            last;
  } digit_beat_t;

  digit_beat_t expected_digits [$];
  digit_beat_t want;
  int          fail_count = 0;
  int          outstanding = 0;

  assign fail_count_o  = fail_count;
  assign outstanding_o = outstanding;

  task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                 input logic [63:0] got_val);
    $display("%0t ns: digit beat %s mismatch, expected %0d got %0d",
             $time, what, exp_val, got_val);
    fail_count++;
  endtask

  // digits of one value, most significant first, leading zeros dropped
  function automatic void queue_digits(input logic [63:0] raw);
    logic [63:0] rest;
    logic [63:0] weight;
    logic [63:0] quot;
    int unsigned count;
    digit_beat_t beat;
    rest   = raw & VALUE_MASK;
    weight = 64'd1;
    count  = 0;
    while (weight <= rest / DECIMAL_BASE) weight = weight * DECIMAL_BASE;
    while (weight != 64'd0 && count < MAX_DIGITS) begin
      quot           = rest / weight;
      beat.digit     = quot[b2d_pkg::DIGIT_WIDTH-1:0];
      beat.magnitude = weight;
      beat.last      = (weight == 64'd1);
      expected_digits.push_back(beat);
      rest   = rest % weight;
      weight = weight / DECIMAL_BASE;
      count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected, digit", 64'd0, 64'(digit_o));
        end else begin
          want = expected_digits.pop_front();
          if (digit_o !== want.digit) report_mismatch("digit", 64'(want.digit), 64'(digit_o));
          if (magnitude_o !== want.magnitude) begin
            report_mismatch("magnitude", want.magnitude, magnitude_o);
          end
          if (last_o !== want.last) report_mismatch("last", 64'(want.last), 64'(last_o));
        end
      end
      if (start_i && !busy_o) queue_digits(value_i);
      outstanding = expected_digits.size();
    end
  end

endmodule

/* dv/binary_to_decimal_digits_top_tb.sv */
// testbench top: drives values into the decimal digit splitter and gives the verdict
`timescale 1ns / 1ps

module binary_to_decimal_digits_top_tb;

  localparam int unsigned VALUE_WIDTH  = 64;
  localparam int unsigned RANDOM_BEATS = 190;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [63:0]                     value_i;
  logic                            valid_o;
  logic [b2d_pkg::DIGIT_WIDTH-1:0] digit_o;
  logic [b2d_pkg::MAG_WIDTH-1:0]   magnitude_o;
  logic                            last_o;
  int                              fail_count;
  int                              outstanding;

  logic [63:0] corner_values [$] = '{
    64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd101, 64'd1000000007,
    64'd999999999999999999, 64'd1000000000000000000, 64'd9999999999999999999,
    64'd10000000000000000000, 64'd10000000000000000001, 64'd18446744073709551615,
    64'd9223372036854775808, 64'd12345678901234567890, 64'h5555555555555555,
    64'haaaaaaaaaaaaaaaa, 64'd10203040506070809000, 64'd90909090909090909
  };

  binary_to_decimal_digits_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .digit_o    (digit_o),
    .magnitude_o(magnitude_o),
    .last_o     (last_o)
  );

  b2d_digit_monitor #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) digit_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .valid_o      (valid_o),
    .digit_o      (digit_o),
    .magnitude_o  (magnitude_o),
    .last_o       (last_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("binary_to_decimal_digits_top test failed");
    $finish;
  end

  // holds start until the beat is taken, returns at the next falling edge
  task automatic send_value(input logic [63:0] v);
    start_i <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start_i <= 1'b0;
    value_i <= {$urandom, $urandom};
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] v;
    logic [63:0] p;
    bit          quiet;
    start_i = 1'b0;
    value_i = 64'd0;
    rst_ni  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (corner_values[i]) begin
      if (i == 10) pause_sender(3);
      send_value(corner_values[i]);
    end

    // sender holds off until every digit has come out
    pause_sender(1);
    while (outstanding != 0) @(negedge clk_i);

    for (int k = 0; k < RANDOM_BEATS; k++) begin
      quiet = (k >= 60 && k < 110);
      if (k == 140) begin
        pause_sender(1);
        while (outstanding != 0) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        pause_sender($urandom_range(1, 100));
      end
      case ($urandom_range(0, 3))
        0: v = {$urandom, $urandom};
        1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        2: begin
          p = 64'd1;
          repeat ($urandom_range(0, 19)) p = p * 64'd10;
          v = p + 64'($urandom_range(0, 4)) - 64'd2;
        end
        default: begin
          // decimal digits with many inner zeros
          v = 64'd0;
          repeat ($urandom_range(1, 20)) begin
            v = v * 64'd10 + ($urandom_range(0, 1) ? 64'($urandom_range(0, 9)) : 64'd0);
          end
        end
      endcase
      send_value(v);
    end

    start_i <= 1'b0;
    value_i <= 64'd0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("binary_to_decimal_digits_top test passed");
    end else begin
      $display("binary_to_decimal_digits_top test failed");
    end
    $finish;
  end

endmodule
